// File: rtl/core/assert_macros.svh
// Assertion macros shared by the ringtone note parser RTL.
// Standalone header; the assertions clock on aclk and reset on aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RNP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define RNP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/rnp_pkg.sv
// Ringtone note parser package: types, codes, microcode ROM and pitch table.
// No dependencies; used by every module of the parser.
package rnp_pkg;

    localparam int unsigned UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SETUP,
        OP_DIV_STEP,
        OP_SH_STEP,
        OP_PUSH_NOTE,
        OP_APPLY,
        OP_PUSH_END
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_VALID,
        C_NO_EMIT,
        C_LOOP_MORE,
        C_SH_ZERO,
        C_SH_MORE,
        C_OUT_FULL,
        C_NOT_NUL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    typedef enum logic [2:0] {
        PH_DIGITS,
        PH_SHARP,
        PH_DOT,
        PH_OCTAVE,
        PH_COMMA
    } phase_t;

    typedef struct packed {
        logic no_emit;
        logic loop_more;
        logic sh_zero;
        logic sh_more;
        logic not_nul;
    } status_t;

    typedef struct packed {
        logic [9:0]  default_duration;
        logic [3:0]  default_octave;
        logic [15:0] whole_note_ms;
    } cfg_t;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_DURATION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_OCTAVE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WHOLE_NOTE_MS    = 2'd2;

    localparam logic [9:0]  RST_DEFAULT_DURATION = 10'd4;
    localparam logic [3:0]  RST_DEFAULT_OCTAVE   = 4'd6;
    localparam logic [15:0] RST_WHOLE_NOTE_MS    = 16'd3808;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_P     = 8'h70;

    localparam logic [3:0]  PITCH_UNKNOWN = 4'd15;
    localparam logic [3:0]  LAST_NATURAL  = 4'd6;
    localparam logic [3:0]  SHARP_OFFSET  = 4'd7;
    localparam logic [9:0]  DACC_MAX      = 10'd1023;
    localparam logic [13:0] FREQ_MAX      = 14'h3FFF;
    localparam logic [15:0] DUR_MAX       = 16'hFFFF;
    localparam logic [4:0]  DIV_STEPS     = 5'd16;

    localparam upc_t UA_WAIT      = 4'd0;
    localparam upc_t UA_DECODE    = 4'd1;
    localparam upc_t UA_SETUP     = 4'd2;
    localparam upc_t UA_DIV       = 4'd3;
    localparam upc_t UA_SH_CHK    = 4'd4;
    localparam upc_t UA_SHIFT     = 4'd5;
    localparam upc_t UA_PUSH_NOTE = 4'd6;
    localparam upc_t UA_APPLY     = 4'd7;
    localparam upc_t UA_PUSH_END  = 4'd8;
    localparam upc_t UA_RETURN    = 4'd9;

    // Base-octave tone per pitch code: a..g, then sharps a#..g# (b#, e# silent).
    function automatic logic [8:0] pitch_hz(input logic [3:0] idx);
        logic [8:0] hz;
        case (idx)
            4'd0:    hz = 9'd220;
            4'd1:    hz = 9'd247;
            4'd2:    hz = 9'd262;
            4'd3:    hz = 9'd294;
            4'd4:    hz = 9'd330;
            4'd5:    hz = 9'd349;
            4'd6:    hz = 9'd392;
            4'd7:    hz = 9'd233;
            4'd9:    hz = 9'd277;
            4'd10:   hz = 9'd311;
            4'd12:   hz = 9'd370;
            4'd13:   hz = 9'd415;
            default: hz = 9'd0;
        endcase
        return hz;
    endfunction

    // Control program: one word per step.
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        case (addr)
            UA_WAIT:      w = '{OP_CAPTURE,   C_NO_VALID,  UA_WAIT};
            UA_DECODE:    w = '{OP_NONE,      C_NO_EMIT,   UA_APPLY};
            UA_SETUP:     w = '{OP_SETUP,     C_ALWAYS,    UA_DIV};
            UA_DIV:       w = '{OP_DIV_STEP,  C_LOOP_MORE, UA_DIV};
            UA_SH_CHK:    w = '{OP_NONE,      C_SH_ZERO,   UA_PUSH_NOTE};
            UA_SHIFT:     w = '{OP_SH_STEP,   C_SH_MORE,   UA_SHIFT};
            UA_PUSH_NOTE: w = '{OP_PUSH_NOTE, C_OUT_FULL,  UA_PUSH_NOTE};
            UA_APPLY:     w = '{OP_APPLY,     C_NOT_NUL,   UA_WAIT};
            UA_PUSH_END:  w = '{OP_PUSH_END,  C_OUT_FULL,  UA_PUSH_END};
            UA_RETURN:    w = '{OP_NONE,      C_ALWAYS,    UA_WAIT};
            default:      w = '{OP_NONE,      C_ALWAYS,    UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/rnp_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on rnp_pkg.
module rnp_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  rnp_pkg::status_t status,
    input  logic             in_valid,
    input  logic             out_full,
    output rnp_pkg::ucode_t  ctrl
);

    rnp_pkg::upc_t   upc_reg;
    rnp_pkg::upc_t   upc_next;
    rnp_pkg::ucode_t word;
    logic            taken;

    always_comb begin
        word = rnp_pkg::ucode_rom(upc_reg);
        case (word.cond)
            rnp_pkg::C_ALWAYS:    taken = 1'b1;
            rnp_pkg::C_NO_VALID:  taken = !in_valid;
            rnp_pkg::C_NO_EMIT:   taken = status.no_emit;
            rnp_pkg::C_LOOP_MORE: taken = status.loop_more;
            rnp_pkg::C_SH_ZERO:   taken = status.sh_zero;
            rnp_pkg::C_SH_MORE:   taken = status.sh_more;
            rnp_pkg::C_OUT_FULL:  taken = out_full;
            rnp_pkg::C_NOT_NUL:   taken = status.not_nul;
            default:              taken = 1'b1;
        endcase
        upc_next = taken ? word.target : rnp_pkg::upc_t'(upc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= rnp_pkg::UA_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl = word;

endmodule

// File: rtl/core/rnp_datapath.sv
// Parser datapath: note state, character decode, iterative divider, octave shifter.
// Depends on rnp_pkg; driven by rnp_sequencer ops.
module rnp_datapath #(
    parameter int unsigned BASE_OCTAVE = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rnp_pkg::op_t     op,
    input  rnp_pkg::cfg_t    cfg,
    input  logic [7:0]       in_char,
    output rnp_pkg::status_t status,
    output logic [13:0]      note_freq,
    output logic [15:0]      note_dur
);

    localparam logic [3:0] BaseOct = 4'(BASE_OCTAVE);

    logic [7:0]       char_reg;
    rnp_pkg::phase_t  phase_reg, phase_next;
    logic [9:0]       dacc_reg, dacc_next;
    logic [3:0]       nidx_reg, nidx_next;
    logic             rest_reg, rest_next;
    logic             dotted_reg, dotted_next;
    logic [3:0]       octd_reg, octd_next;
    logic             pending_reg, pending_next;

    logic [15:0] quo_reg;
    logic [9:0]  rem_reg;
    logic [9:0]  dvs_reg;
    logic        dzero_reg;
    logic [4:0]  cnt_reg;
    logic [13:0] freq_reg;
    logic [3:0]  shcnt_reg;

    logic        c_nul, c_comma, is_dig, is_letter;
    logic        sharp_hit, dot_hit, oct_hit, emit_now;
    logic [9:0]  acc_base;
    logic [13:0] mac;
    logic [9:0]  mac_sat;
    logic [7:0]  letter_off;
    logic [10:0] trial;
    logic        ge;
    logic [9:0]  div_sel;
    logic [3:0]  oct_eff;
    logic [15:0] q;
    logic [16:0] dsum;

    // character decode against the current note state
    always_comb begin
        c_nul     = (char_reg == rnp_pkg::CH_NUL);
        c_comma   = (char_reg == rnp_pkg::CH_COMMA);
        is_dig    = (char_reg >= rnp_pkg::CH_ZERO) && (char_reg <= rnp_pkg::CH_NINE);
        is_letter = (char_reg >= rnp_pkg::CH_A) && (char_reg <= rnp_pkg::CH_G);
        sharp_hit = (phase_reg == rnp_pkg::PH_SHARP) && (char_reg == rnp_pkg::CH_SHARP);
        dot_hit   = ((phase_reg == rnp_pkg::PH_SHARP) || (phase_reg == rnp_pkg::PH_DOT))
                    && (char_reg == rnp_pkg::CH_DOT);
        oct_hit   = ((phase_reg == rnp_pkg::PH_SHARP) || (phase_reg == rnp_pkg::PH_DOT)
                    || (phase_reg == rnp_pkg::PH_OCTAVE)) && is_dig;
        emit_now  = (c_nul && pending_reg) || c_comma
                    || (!c_nul && (phase_reg != rnp_pkg::PH_DIGITS)
                        && !sharp_hit && !dot_hit && !oct_hit);
        acc_base   = (phase_reg == rnp_pkg::PH_DIGITS) ? dacc_reg : 10'd0;
        mac        = 14'({acc_base, 3'b000}) + 14'({acc_base, 1'b0}) + 14'(char_reg[3:0]);
        mac_sat    = (mac > 14'(rnp_pkg::DACC_MAX)) ? rnp_pkg::DACC_MAX : mac[9:0];
        letter_off = char_reg - rnp_pkg::CH_A;
    end

    // note state update
    always_comb begin
        phase_next   = phase_reg;
        dacc_next    = dacc_reg;
        nidx_next    = nidx_reg;
        rest_next    = rest_reg;
        dotted_next  = dotted_reg;
        octd_next    = octd_reg;
        pending_next = pending_reg;
        if (op == rnp_pkg::OP_APPLY) begin
            if (c_nul || c_comma) begin
                phase_next   = rnp_pkg::PH_DIGITS;
                dacc_next    = '0;
                nidx_next    = rnp_pkg::PITCH_UNKNOWN;
                rest_next    = 1'b0;
                dotted_next  = 1'b0;
                octd_next    = '0;
                pending_next = 1'b0;
            end else if (sharp_hit) begin
                if (nidx_reg <= rnp_pkg::LAST_NATURAL) begin
                    nidx_next = nidx_reg + rnp_pkg::SHARP_OFFSET;
                end
                phase_next = rnp_pkg::PH_DOT;
            end else if (dot_hit) begin
                dotted_next = 1'b1;
                phase_next  = rnp_pkg::PH_OCTAVE;
            end else if (oct_hit) begin
                octd_next  = char_reg[3:0];
                phase_next = rnp_pkg::PH_COMMA;
            end else begin
                // previous note closed by this character: it opens a fresh one
                if (phase_reg != rnp_pkg::PH_DIGITS) begin
                    phase_next  = rnp_pkg::PH_DIGITS;
                    dacc_next   = '0;
                    nidx_next   = rnp_pkg::PITCH_UNKNOWN;
                    rest_next   = 1'b0;
                    dotted_next = 1'b0;
                    octd_next   = '0;
                end
                pending_next = 1'b1;
                if (is_dig) begin
                    dacc_next = mac_sat;
                end else if (char_reg == rnp_pkg::CH_P) begin
                    rest_next  = 1'b1;
                    phase_next = rnp_pkg::PH_DOT;
                end else begin
                    nidx_next  = is_letter ? letter_off[3:0] : rnp_pkg::PITCH_UNKNOWN;
                    phase_next = rnp_pkg::PH_SHARP;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= rnp_pkg::PH_DIGITS;
            dacc_reg    <= '0;
            nidx_reg    <= '0;
            rest_reg    <= 1'b0;
            dotted_reg  <= 1'b0;
            octd_reg    <= '0;
            pending_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            dacc_reg    <= dacc_next;
            nidx_reg    <= nidx_next;
            rest_reg    <= rest_next;
            dotted_reg  <= dotted_next;
            octd_reg    <= octd_next;
            pending_reg <= pending_next;
        end
    end

    // divider and shifter operands
    always_comb begin
        div_sel = (dacc_reg != 10'd0) ? dacc_reg : cfg.default_duration;
        oct_eff = (octd_reg != 4'd0) ? octd_reg : cfg.default_octave;
        trial   = {rem_reg, quo_reg[15]};
        ge      = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        case (op)
            rnp_pkg::OP_CAPTURE: begin
                char_reg <= in_char;
            end
            rnp_pkg::OP_SETUP: begin
                quo_reg   <= cfg.whole_note_ms;
                rem_reg   <= '0;
                dvs_reg   <= div_sel;
                dzero_reg <= (div_sel == 10'd0);
                cnt_reg   <= rnp_pkg::DIV_STEPS;
                freq_reg  <= rest_reg ? 14'd0 : 14'(rnp_pkg::pitch_hz(nidx_reg));
                shcnt_reg <= (oct_eff > BaseOct) ? (oct_eff - BaseOct) : 4'd0;
            end
            rnp_pkg::OP_DIV_STEP: begin
                rem_reg <= ge ? 10'(trial - {1'b0, dvs_reg}) : trial[9:0];
                quo_reg <= {quo_reg[14:0], ge};
                cnt_reg <= cnt_reg - 5'd1;
            end
            rnp_pkg::OP_SH_STEP: begin
                freq_reg  <= freq_reg[13] ? rnp_pkg::FREQ_MAX : {freq_reg[12:0], 1'b0};
                shcnt_reg <= shcnt_reg - 4'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        q         = dzero_reg ? 16'd0 : quo_reg;
        dsum      = {1'b0, q} + (dotted_reg ? {2'b00, q[15:1]} : 17'd0);
        note_dur  = dsum[16] ? rnp_pkg::DUR_MAX : dsum[15:0];
        note_freq = freq_reg;

        status.no_emit   = !emit_now;
        status.loop_more = (cnt_reg != 5'd1);
        status.sh_zero   = (shcnt_reg == 4'd0);
        status.sh_more   = (shcnt_reg != 4'd1);
        status.not_nul   = !c_nul;
    end

endmodule

// File: rtl/core/ringtone_note_parser_top.sv
// Ringtone note parser: one character per item, the next accepted once the last is done.
// A character that closes no note is captured, decoded and applied. A closing character
// also runs the restoring divider and the octave shifter (doubling per octave above the
// base) and pushes its note item; a NUL adds an end item. Output stalls hold each push.
// Reset (synchronous, aresetn low) clears the note state, loads the register defaults
// and empties the output stage.
`include "assert_macros.svh"

module ringtone_note_parser_top #(
    parameter int unsigned BASE_OCTAVE = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] character
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [13:0] frequency_hz, [29:14] duration_ms
    output logic                            m_tlast,   // song_end
    input  logic                            cfg_we,
    input  logic [rnp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rnp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    rnp_pkg::cfg_t    cfg_reg;
    rnp_pkg::ucode_t  ctrl;
    rnp_pkg::status_t status;
    logic [13:0]      note_freq;
    logic [15:0]      note_dur;
    logic             out_full;
    logic             push_note, push_end;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [31:0]      m_tdata_reg;
    logic             m_tlast_reg;

    rnp_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .in_valid (s_tvalid),
        .out_full (out_full),
        .ctrl     (ctrl)
    );

    rnp_datapath #(
        .BASE_OCTAVE (BASE_OCTAVE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (ctrl.op),
        .cfg       (cfg_reg),
        .in_char   (s_tdata),
        .status    (status),
        .note_freq (note_freq),
        .note_dur  (note_dur)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_duration <= rnp_pkg::RST_DEFAULT_DURATION;
            cfg_reg.default_octave   <= rnp_pkg::RST_DEFAULT_OCTAVE;
            cfg_reg.whole_note_ms    <= rnp_pkg::RST_WHOLE_NOTE_MS;
        end else if (cfg_we) begin
            case (cfg_addr)
                rnp_pkg::REG_DEFAULT_DURATION: cfg_reg.default_duration <= cfg_wdata[9:0];
                rnp_pkg::REG_DEFAULT_OCTAVE:   cfg_reg.default_octave   <= cfg_wdata[3:0];
                rnp_pkg::REG_WHOLE_NOTE_MS:    cfg_reg.whole_note_ms    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // output stage
    always_comb begin
        s_tready  = (ctrl.op == rnp_pkg::OP_CAPTURE);
        out_full  = m_tvalid_reg && !m_tready;
        push_note = !out_full && (ctrl.op == rnp_pkg::OP_PUSH_NOTE);
        push_end  = !out_full && (ctrl.op == rnp_pkg::OP_PUSH_END);
        if (push_note || push_end) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_note) begin
            m_tdata_reg <= {2'b00, note_dur, note_freq};
            m_tlast_reg <= 1'b0;
        end else if (push_end) begin
            m_tdata_reg <= '0;
            m_tlast_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `RNP_ASSERT(a_no_back_to_back_accept, (s_tvalid && s_tready) |=> !s_tready, "item accepted on consecutive cycles")
    `RNP_ASSERT(a_end_only_after_nul, (ctrl.op == rnp_pkg::OP_PUSH_END) |-> !status.not_nul, "end item without NUL")
    `RNP_ASSERT(a_push_kinds_exclusive, (ctrl.op == rnp_pkg::OP_PUSH_NOTE) |-> !s_tready, "note push while taking input")
    `RNP_ASSERT_ALWAYS(a_reset_empties_out, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
